// File: sv/gyrc_pkg.sv
// ----------------------------------------------------------------------------
// gyrc_pkg: shared types and constants of the yaw-rate correction loop
// Item layouts, serial arithmetic request types and fixed-point constants.
// ----------------------------------------------------------------------------
package gyrc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DELAY_W   = 16;

  // Serial multiplier: 64-bit multiplicand, up to 48 multiplier bits.
  localparam int unsigned MUL_A_W   = 64;
  localparam int unsigned MUL_B_W   = 48;
  localparam int unsigned MUL_CNT_W = 6;
  localparam int unsigned MUL_ACC_W = 66;

  // Serial divider: 64-bit dividend, 32-bit divisor.
  localparam int unsigned DIV_N_W   = 64;
  localparam int unsigned DIV_D_W   = 32;
  localparam int unsigned DIV_CNT_W = 7;

  // Q4.20 constants.
  localparam logic [33:0] Q_PI     = 34'd3294199;
  localparam logic [33:0] Q_TWO_PI = 34'd6588397;
  localparam logic [31:0] Q_ONE    = 32'd1048576;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_PROP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_INTEG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_PROP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_DELAY    = 2'd3;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_47,
    CAP_62
  } cap_sel_e;

  typedef struct packed {
    logic [31:0]        time_tick;
    logic signed [31:0] speed_reference;
    logic signed [31:0] rate_reference;
    logic signed [31:0] rate_measured;
    logic signed [31:0] heading_measured;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rate_command;
    logic               stale_hold;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [MUL_A_W-1:0]   a;
    logic [MUL_B_W-1:0]   b;    // left-justified, MSB first
    logic [MUL_CNT_W-1:0] len;  // number of multiplier bits to consume
    cap_sel_e             cap;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: sv/gyrc_serial_mul.sv
// ----------------------------------------------------------------------------
// gyrc_serial_mul: bit-serial saturating multiplier
// Consumes one multiplier bit per cycle, MSB first, and caps the magnitude.
// ----------------------------------------------------------------------------
module gyrc_serial_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gyrc_pkg::mul_req_t   req_i,
  output gyrc_pkg::unit_stat_t stat_o,
  output logic [63:0]          prod_o
);
  import gyrc_pkg::*;

  logic [MUL_ACC_W-1:0] acc_q, acc_d, cap_q, cap_d, nxt;
  logic [MUL_A_W-1:0]   a_q, a_d;
  logic [MUL_B_W-1:0]   b_q, b_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 ovf_q, ovf_d, busy_q, busy_d, done_q, done_d;

  assign nxt = {acc_q[MUL_ACC_W-2:0], 1'b0} +
               (b_q[MUL_B_W-1] ? {2'b00, a_q} : '0);

  always_comb begin
    acc_d  = acc_q;
    cap_d  = cap_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      acc_d  = '0;
      ovf_d  = 1'b0;
      a_d    = req_i.a;
      b_d    = req_i.b;
      cnt_d  = req_i.len;
      busy_d = 1'b1;
      unique case (req_i.cap)
        CAP_47:  cap_d = MUL_ACC_W'(1) << 47;
        CAP_62:  cap_d = MUL_ACC_W'(1) << 62;
        default: cap_d = MUL_ACC_W'(1) << 64;
      endcase
    end else if (busy_q) begin
      // Partial sums only grow, so once past the cap the result is the cap.
      if (!ovf_q) begin
        if (nxt > cap_q) ovf_d = 1'b1;
        else acc_d = nxt;
      end
      b_d   = {b_q[MUL_B_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MUL_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ovf_q  <= ovf_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    cap_q <= cap_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = ovf_q ? cap_q[63:0] : acc_q[63:0];

endmodule

// File: sv/gyrc_serial_div.sv
// ----------------------------------------------------------------------------
// gyrc_serial_div: restoring divider
// Unsigned 64 by 32 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gyrc_serial_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gyrc_pkg::div_req_t   req_i,
  output gyrc_pkg::unit_stat_t stat_o,
  output logic [63:0]          quo_o
);
  import gyrc_pkg::*;

  logic [DIV_D_W-1:0]   rem_q, rem_d, den_q, den_d;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [DIV_D_W:0]     shifted, trial;

  assign shifted = {rem_q, quo_q[DIV_N_W-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      den_d  = req_i.den;
      quo_d  = req_i.num;
      cnt_d  = DIV_CNT_W'(DIV_N_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The dividend shifts out of the top as quotient bits shift in below.
      if (!trial[DIV_D_W]) begin
        rem_d = trial[DIV_D_W-1:0];
        quo_d = {quo_q[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIV_D_W-1:0];
        quo_d = {quo_q[DIV_N_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

// File: sv/gyro_yaw_rate_correction_loop_core.sv
// ----------------------------------------------------------------------------
// gyro_yaw_rate_correction_loop_core: yaw-rate command correction
// Heading PI hold, rate jumps and rate P feedback on one yaw-rate command.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | input     | in_valid/in_stall  | in_item_t (time, refs, meas)
//   out     | output    | out_valid/out_stall| out_item_t (command, stale)
//   cfg     | input     | cfg_valid/ready    | register index and data
//
// One item at a time. Direct cases finish without the serial units; the heading
// PI loop runs five serial multiplies of 32 or 48 bit steps; rate feedback with a
// scaling step runs three multiplies and a 64 step division.
// Reset is asynchronous and returns all history to its initial values.
// A result waiting under out_stall blocks only the final step of the next item.
// ----------------------------------------------------------------------------
module gyro_yaw_rate_correction_loop_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  gyrc_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output gyrc_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gyrc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gyrc_pkg::DATA_W-1:0]       cfg_data_i
);
  import gyrc_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECIDE = 4'd1;
  localparam logic [3:0] ST_PI_M1  = 4'd2;
  localparam logic [3:0] ST_PI_M2  = 4'd3;
  localparam logic [3:0] ST_PI_M3  = 4'd4;
  localparam logic [3:0] ST_PI_M4  = 4'd5;
  localparam logic [3:0] ST_PI_M5  = 4'd6;
  localparam logic [3:0] ST_SC_MUL = 4'd7;
  localparam logic [3:0] ST_SC_DIV = 4'd8;
  localparam logic [3:0] ST_RATE   = 4'd9;
  localparam logic [3:0] ST_RT_M1  = 4'd10;
  localparam logic [3:0] ST_RT_M2  = 4'd11;
  localparam logic [3:0] ST_FINISH = 4'd12;

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    abs32 = x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic signed [31:0] sat41(input logic signed [40:0] x);
    if (x > 41'sd2147483647) sat41 = 32'sh7fffffff;
    else if (x < -41'sd2147483648) sat41 = 32'sh80000000;
    else sat41 = x[31:0];
  endfunction

  // Configuration and history.
  logic [31:0]        hpg_q, hpg_d, hig_q, hig_d, rpg_q, rpg_d;
  logic [15:0]        delay_q, delay_d;
  logic               first_q, first_d, straight_q, straight_d;
  logic signed [31:0] held_q, held_d;
  logic signed [47:0] sum_q, sum_d;
  logic signed [31:0] last_ref_q, last_ref_d, last_meas_q, last_meas_d;
  logic signed [31:0] last_cmd_q, last_cmd_d;
  logic [31:0]        last_time_q, last_time_d, jump_time_q, jump_time_d;

  // Item and working registers.
  logic [3:0]         state_q, state_d;
  logic [31:0]        t_q;
  logic               speed_nz_q;
  logic signed [31:0] ref_q, meas_q, head_q;
  logic signed [31:0] cmd_q, cmd_d;
  logic               stale_q, stale_d;
  logic signed [33:0] err_q, err_d;
  logic signed [47:0] sum_new_q, sum_new_d;
  logic signed [39:0] t1_q, t1_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;
  mul_req_t           mul_req_q, mul_req_d;
  div_req_t           div_req_q, div_req_d;

  unit_stat_t         mul_stat, div_stat;
  logic [63:0]        mul_res, div_quo;
  logic               accept;

  // Decision terms.
  logic [31:0]        dt, ar, ap, elapsed;
  logic [35:0]        ap10;
  logic [36:0]        ar20;
  logic [33:0]        ap3, ar3;
  logic               prev_nz, rise, ratio, opposite, same, jump_a, jump_b, late;
  logic               scale_later, meas_same;
  logic signed [33:0] diff, diff_wrap;
  logic [33:0]        err_mag;
  logic [47:0]        sum_mag;
  logic signed [32:0] rm;
  logic [32:0]        rm_mag;
  logic signed [48:0] sum_ext;
  logic signed [39:0] gterm;
  logic               scale_neg;
  logic signed [31:0] scaled;

  gyrc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req_q),
    .stat_o (mul_stat),
    .prod_o (mul_res)
  );

  gyrc_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign dt       = t_q - last_time_q;
  assign ar       = abs32(ref_q);
  assign ap       = abs32(last_ref_q);
  assign ap10     = {1'b0, ap, 3'b000} + {3'b000, ap, 1'b0};
  assign prev_nz  = ap10 < 36'(Q_ONE);
  assign ar20     = {1'b0, ar, 4'b0000} + {3'b000, ar, 2'b00};
  assign rise     = ar20 >= 37'(3 * Q_ONE);
  assign ap3      = {1'b0, ap, 1'b0} + {2'b00, ap};
  assign ar3      = {1'b0, ar, 1'b0} + {2'b00, ar};
  assign ratio    = ({1'b0, ar, 1'b0} > ap3) || ({1'b0, ap, 1'b0} > ar3);
  assign opposite = (ref_q < 0 && last_ref_q > 0) || (ref_q > 0 && last_ref_q < 0);
  assign same     = (ref_q < 0 && last_ref_q < 0) || (ref_q > 0 && last_ref_q > 0);
  assign jump_a   = opposite || (prev_nz && rise);
  assign jump_b   = !prev_nz && same && ratio;
  assign elapsed  = t_q - jump_time_q;
  assign late     = elapsed >= {16'h0000, delay_q};
  assign meas_same = (meas_q == last_meas_q);
  // Inside the lock delay with no new jump, a changed reference that was not near zero scales the command by the ratio.
  assign scale_later = !jump_a && !jump_b && !late && (t_q != jump_time_q) &&
                       !(prev_nz || ref_q == last_ref_q);

  // A difference above pi cannot fall below minus pi after one wrap.
  assign diff      = 34'(held_q) - 34'(head_q);
  assign diff_wrap = (diff > $signed(Q_PI)) ? diff - $signed(Q_TWO_PI) :
                     (diff < -$signed(Q_PI)) ? diff + $signed(Q_TWO_PI) : diff;
  assign err_mag   = err_q[33] ? 34'(-err_q) : 34'(err_q);
  assign sum_mag   = sum_new_q[47] ? 48'(-sum_new_q) : 48'(sum_new_q);
  assign rm        = 33'(ref_q) - 33'(meas_q);
  assign rm_mag    = rm[32] ? 33'(-rm) : 33'(rm);

  assign sum_ext = 49'(sum_q) + (err_q[33] ? -$signed({1'b0, mul_res[47:0]})
                                           : $signed({1'b0, mul_res[47:0]}));
  assign gterm   = $signed({1'b0, mul_res[62:24]});

  assign scale_neg = last_cmd_q[31] ^ ref_q[31] ^ last_ref_q[31];
  always_comb begin
    if (!scale_neg) begin
      scaled = (div_quo > 64'd2147483647) ? 32'sh7fffffff : $signed(div_quo[31:0]);
    end else begin
      scaled = (div_quo > 64'd2147483648) ? 32'sh80000000 : $signed(32'(-div_quo[31:0]));
    end
  end

  always_comb begin
    hpg_d       = hpg_q;
    hig_d       = hig_q;
    rpg_d       = rpg_q;
    delay_d     = delay_q;
    first_d     = first_q;
    straight_d  = straight_q;
    held_d      = held_q;
    sum_d       = sum_q;
    last_ref_d  = last_ref_q;
    last_meas_d = last_meas_q;
    last_cmd_d  = last_cmd_q;
    last_time_d = last_time_q;
    jump_time_d = jump_time_q;
    state_d     = state_q;
    cmd_d       = cmd_q;
    stale_d     = stale_q;
    err_d       = err_q;
    sum_new_d   = sum_new_q;
    t1_d        = t1_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_req_d   = mul_req_q;
    mul_req_d.start = 1'b0;
    div_req_d   = div_req_q;
    div_req_d.start = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HEADING_PROP:  hpg_d   = cfg_data_i;
        REG_HEADING_INTEG: hig_d   = cfg_data_i;
        REG_RATE_PROP:     rpg_d   = cfg_data_i;
        REG_LOCK_DELAY:    delay_d = cfg_data_i[15:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECIDE;
          cmd_d   = last_cmd_q;
          stale_d = 1'b0;
        end
      end
      ST_DECIDE: begin
        state_d = ST_FINISH;
        if (first_q) begin
          cmd_d       = ref_q;
          first_d     = 1'b0;
          jump_time_d = '0;
        end else if (ref_q == 0) begin
          if (!speed_nz_q) begin
            cmd_d      = '0;
            straight_d = 1'b0;
          end else if (!straight_q) begin
            cmd_d      = '0;
            straight_d = 1'b1;
            held_d     = head_q;
            sum_d      = '0;
          end else if (meas_same) begin
            stale_d = 1'b1;
          end else begin
            err_d           = diff_wrap;
            mul_req_d.start = 1'b1;
            mul_req_d.a     = 64'(diff_wrap[33] ? 34'(-diff_wrap) : 34'(diff_wrap));
            mul_req_d.b     = {dt, 16'h0000};
            mul_req_d.len   = MUL_CNT_W'(32);
            mul_req_d.cap   = CAP_47;
            state_d         = ST_PI_M1;
          end
        end else begin
          if (jump_a) cmd_d = ref_q;
          if (jump_a || jump_b) jump_time_d = t_q;
          if (jump_b || scale_later) begin
            mul_req_d.start = 1'b1;
            mul_req_d.a     = 64'(abs32(last_cmd_q));
            mul_req_d.b     = {ar, 16'h0000};
            mul_req_d.len   = MUL_CNT_W'(32);
            mul_req_d.cap   = CAP_NONE;
            state_d         = ST_SC_MUL;
          end else begin
            state_d = ST_RATE;
          end
        end
      end
      ST_PI_M1: begin
        if (mul_stat.done) begin
          if (sum_ext > 49'sh7fffffffffff) sum_new_d = 48'sh7fffffffffff;
          else if (sum_ext < -49'sh800000000000) sum_new_d = 48'sh800000000000;
          else sum_new_d = sum_ext[47:0];
          mul_req_d.start = 1'b1;
          mul_req_d.a     = 64'(hpg_q);
          mul_req_d.b     = {dt, 16'h0000};
          mul_req_d.len   = MUL_CNT_W'(32);
          mul_req_d.cap   = CAP_NONE;
          state_d         = ST_PI_M2;
        end
      end
      ST_PI_M2: begin
        if (mul_stat.done) begin
          mul_req_d.start = 1'b1;
          mul_req_d.a     = mul_res;
          mul_req_d.b     = 48'(err_mag);
          mul_req_d.len   = MUL_CNT_W'(MUL_B_W);
          mul_req_d.cap   = CAP_62;
          state_d         = ST_PI_M3;
        end
      end
      ST_PI_M3: begin
        if (mul_stat.done) begin
          t1_d            = err_q[33] ? -gterm : gterm;
          mul_req_d.start = 1'b1;
          mul_req_d.a     = 64'(hig_q);
          mul_req_d.b     = {dt, 16'h0000};
          mul_req_d.len   = MUL_CNT_W'(32);
          mul_req_d.cap   = CAP_NONE;
          state_d         = ST_PI_M4;
        end
      end
      ST_PI_M4: begin
        if (mul_stat.done) begin
          mul_req_d.start = 1'b1;
          mul_req_d.a     = mul_res;
          mul_req_d.b     = sum_mag;
          mul_req_d.len   = MUL_CNT_W'(MUL_B_W);
          mul_req_d.cap   = CAP_62;
          state_d         = ST_PI_M5;
        end
      end
      ST_PI_M5: begin
        if (mul_stat.done) begin
          cmd_d   = sat41(41'(t1_q) + 41'(sum_new_q[47] ? -gterm : gterm));
          sum_d   = sum_new_q;
          state_d = ST_FINISH;
        end
      end
      ST_SC_MUL: begin
        if (mul_stat.done) begin
          div_req_d.start = 1'b1;
          div_req_d.num   = mul_res;
          div_req_d.den   = ap;
          state_d         = ST_SC_DIV;
        end
      end
      ST_SC_DIV: begin
        if (div_stat.done) begin
          cmd_d   = scaled;
          state_d = ST_RATE;
        end
      end
      ST_RATE: begin
        if (late && meas_same) begin
          stale_d = 1'b1;
          state_d = ST_FINISH;
        end else begin
          straight_d = 1'b0;
          if (late) begin
            mul_req_d.start = 1'b1;
            mul_req_d.a     = 64'(rpg_q);
            mul_req_d.b     = {dt, 16'h0000};
            mul_req_d.len   = MUL_CNT_W'(32);
            mul_req_d.cap   = CAP_NONE;
            state_d         = ST_RT_M1;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_RT_M1: begin
        if (mul_stat.done) begin
          mul_req_d.start = 1'b1;
          mul_req_d.a     = mul_res;
          mul_req_d.b     = 48'(rm_mag);
          mul_req_d.len   = MUL_CNT_W'(MUL_B_W);
          mul_req_d.cap   = CAP_62;
          state_d         = ST_RT_M2;
        end
      end
      ST_RT_M2: begin
        if (mul_stat.done) begin
          cmd_d   = sat41(41'(last_cmd_q) + 41'(rm[32] ? -gterm : gterm));
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.rate_command = cmd_q;
          out_d.stale_hold   = stale_q;
          out_valid_d        = 1'b1;
          if (!stale_q) begin
            last_ref_d  = ref_q;
            last_meas_d = meas_q;
            last_cmd_d  = cmd_q;
            last_time_d = t_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpg_q       <= '0;
      hig_q       <= '0;
      rpg_q       <= '0;
      delay_q     <= '0;
      first_q     <= 1'b1;
      straight_q  <= 1'b0;
      held_q      <= '0;
      sum_q       <= '0;
      last_ref_q  <= '0;
      last_meas_q <= '0;
      last_cmd_q  <= '0;
      last_time_q <= '0;
      jump_time_q <= '0;
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mul_req_q   <= '0;
      div_req_q   <= '0;
    end else begin
      hpg_q       <= hpg_d;
      hig_q       <= hig_d;
      rpg_q       <= rpg_d;
      delay_q     <= delay_d;
      first_q     <= first_d;
      straight_q  <= straight_d;
      held_q      <= held_d;
      sum_q       <= sum_d;
      last_ref_q  <= last_ref_d;
      last_meas_q <= last_meas_d;
      last_cmd_q  <= last_cmd_d;
      last_time_q <= last_time_d;
      jump_time_q <= jump_time_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      mul_req_q   <= mul_req_d;
      div_req_q   <= div_req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q        <= in_data_i.time_tick;
      speed_nz_q <= (in_data_i.speed_reference != 0);
      ref_q      <= in_data_i.rate_reference;
      meas_q     <= in_data_i.rate_measured;
      head_q     <= in_data_i.heading_measured;
    end
    cmd_q     <= cmd_d;
    stale_q   <= stale_d;
    err_q     <= err_d;
    sum_new_q <= sum_new_d;
    t1_q      <= t1_d;
    out_q     <= out_d;
  end

  // An accepted transfer always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted item did not start processing");

  // A new result appears only out of the final step.
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside the final step");

  // The sequencer never restarts an arithmetic unit that is still running.
  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req_q.start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |-> !div_stat.busy)
    else $error("divider started while busy");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the yaw-rate correction loop
// Drives directed and random items through the stall handshakes, predicts each
// command with a loop model or a typed row, and compares every result field.
// ----------------------------------------------------------------------------
module tb_top;
  import gyrc_pkg::*;

  localparam longint unsigned CAP_HI  = 64'd1 << 62;
  localparam longint unsigned CAP_SUM = 64'd1 << 47;
  localparam longint          PI_Q    = 64'sd3294199;
  localparam longint          TWO_PI_Q = 64'sd6588397;
  localparam longint          ONE_Q   = 64'sd1048576;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  gyro_yaw_rate_correction_loop_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o,
    .out_stall_i, .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // Loop gains and delay as the block should hold them.
  logic [31:0] head_kp, head_ki, rate_kp;
  logic [15:0] lock_delay;
  // Loop history.
  bit          m_first, m_straight;
  longint      m_held, m_err_sum, m_last_ref, m_last_meas, m_last_cmd;
  logic [31:0] m_last_t, m_jump_t;

  out_item_t   cmd_expect_q[$];
  int          err_count = 0;
  bit          typed_valid = 1'b0;
  out_item_t   typed_cmd;
  bit          long_hold_req = 1'b0;

  function automatic longint unsigned mag(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint unsigned capped_mul(longint unsigned a, longint unsigned b,
                                                 longint unsigned cap);
    longint unsigned p;
    if (a != 0 && b > cap / a) return cap;
    p = a * b;
    return p > cap ? cap : p;
  endfunction

  function automatic longint gain_product(longint unsigned gain_dt, longint x);
    longint unsigned p;
    p = capped_mul(gain_dt, mag(x), CAP_HI) >> 24;
    return x < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit is_near_zero(longint x);
    return mag(x) * 10 < longint'(ONE_Q);
  endfunction

  function automatic longint rescale(longint cmd, longint num, longint den);
    return clip32((cmd * num) / den);
  endfunction

  // Advances the loop history by one item and returns the command it produces.
  function automatic out_item_t yaw_cmd_predict(in_item_t it);
    out_item_t       res;
    logic [31:0]     t, dt, since_jump;
    longint          spd, ref_r, meas, head, cmd, prev, err, s;
    longint unsigned ar, ap, m;
    bit              stale, opposite, same_sign;
    t     = it.time_tick;
    spd   = longint'(it.speed_reference);
    ref_r = longint'(it.rate_reference);
    meas  = longint'(it.rate_measured);
    head  = longint'(it.heading_measured);
    cmd   = m_last_cmd;
    stale = 1'b0;
    if (m_first) begin
      cmd = ref_r;
      m_first = 1'b0;
      m_jump_t = '0;
    end else begin
      dt = t - m_last_t;
      prev = m_last_ref;
      if (ref_r == 0) begin
        if (spd != 0) begin
          if (m_straight) begin
            if (meas == m_last_meas) begin
              stale = 1'b1;
            end else begin
              err = m_held - head;
              if (err > PI_Q) err -= TWO_PI_Q;
              if (err < -PI_Q) err += TWO_PI_Q;
              m = capped_mul(mag(err), longint'(dt), CAP_SUM);
              s = m_err_sum + (err < 0 ? -longint'(m) : longint'(m));
              if (s > longint'(CAP_SUM) - 1) s = longint'(CAP_SUM) - 1;
              if (s < -longint'(CAP_SUM)) s = -longint'(CAP_SUM);
              m_err_sum = s;
              cmd = clip32(gain_product(longint'(head_kp) * longint'(dt), err) +
                           gain_product(longint'(head_ki) * longint'(dt), s));
            end
          end else begin
            cmd = 0;
            m_straight = 1'b1;
            m_held = head;
            m_err_sum = 0;
          end
        end else begin
          cmd = 0;
          m_straight = 1'b0;
        end
      end else begin
        ar = mag(ref_r);
        ap = mag(prev);
        opposite  = (ref_r < 0 && prev > 0) || (ref_r > 0 && prev < 0);
        same_sign = (ref_r < 0 && prev < 0) || (ref_r > 0 && prev > 0);
        if (opposite || (is_near_zero(prev) && ar * 20 >= 3 * longint'(ONE_Q))) begin
          cmd = ref_r;
          m_jump_t = t;
        end
        if (!is_near_zero(prev) && same_sign && (ar * 2 > ap * 3 || ap * 2 > ar * 3)) begin
          cmd = rescale(m_last_cmd, ref_r, prev);
          m_jump_t = t;
        end
        since_jump = t - m_jump_t;
        if (since_jump >= {16'd0, lock_delay}) begin
          if (meas == m_last_meas) begin
            stale = 1'b1;
          end else begin
            cmd = clip32(m_last_cmd +
                         gain_product(longint'(rate_kp) * longint'(dt), ref_r - meas));
          end
        end else if (t != m_jump_t) begin
          if (is_near_zero(prev) || ref_r == prev) cmd = m_last_cmd;
          else cmd = rescale(m_last_cmd, ref_r, prev);
        end
        if (!stale) m_straight = 1'b0;
      end
    end
    if (!stale) begin
      m_last_ref = ref_r;
      m_last_meas = meas;
      m_last_cmd = cmd;
      m_last_t = t;
    end
    res.rate_command = cmd[31:0];
    res.stale_hold = stale;
    return res;
  endfunction

  // Input and output transfer monitors.
  always @(posedge clk_i) begin
    out_item_t pred;
    if (in_valid_i && !in_stall_o) begin
      pred = yaw_cmd_predict(in_data_i);
      cmd_expect_q.push_back(typed_valid ? typed_cmd : pred);
    end
    if (out_valid_o && !out_stall_i) begin
      if (cmd_expect_q.size() == 0) begin
        $display("%0t: result with none expected: cmd %h stale %b", $time,
                 out_data_o.rate_command, out_data_o.stale_hold);
        err_count++;
      end else begin
        pred = cmd_expect_q.pop_front();
        if (pred.rate_command !== out_data_o.rate_command) begin
          $display("%0t: rate_command expected %h actual %h", $time,
                   pred.rate_command, out_data_o.rate_command);
          err_count++;
        end
        if (pred.stale_hold !== out_data_o.stale_hold) begin
          $display("%0t: stale_hold expected %b actual %b", $time,
                   pred.stale_hold, out_data_o.stale_hold);
          err_count++;
        end
      end
    end
  end

  // Receiver: random stall before each result, with quiet stretches and one long hold.
  initial begin
    int n, quiet;
    quiet = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (quiet > 0) begin
        n = 0;
        quiet--;
      end else begin
        n = $urandom_range(0, 18);
        if ($urandom_range(0, 15) == 0) quiet = $urandom_range(5, 30);
      end
      if (long_hold_req) begin
        n = 1500;
        long_hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  int send_quiet = 0;

  // Offers one item after a random gap; returns at the falling edge after its transfer.
  task automatic send_item(in_item_t it);
    int n;
    if (send_quiet > 0) begin
      n = 0;
      send_quiet--;
    end else begin
      n = $urandom_range(0, 18);
      if ($urandom_range(0, 15) == 0) send_quiet = $urandom_range(5, 30);
    end
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] kp, logic [31:0] ki, logic [31:0] kr,
                            logic [15:0] dly);
    logic [31:0] vals[4];
    logic [CFG_IDX_W-1:0] idx[4];
    vals = '{kp, ki, kr, {16'd0, dly}};
    idx  = '{REG_HEADING_PROP, REG_HEADING_INTEG, REG_RATE_PROP, REG_LOCK_DELAY};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        REG_HEADING_PROP:  head_kp = vals[i];
        REG_HEADING_INTEG: head_ki = vals[i];
        REG_RATE_PROP:     rate_kp = vals[i];
        REG_LOCK_DELAY:    lock_delay = vals[i][15:0];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (cmd_expect_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // Random item source: noisy straight or turning segments, some fully random items.
  logic [31:0] g_t = 32'd1000;
  logic [31:0] g_ref = '0, g_meas = '0, g_head = '0;
  int          g_seg = 0;
  bit          g_turn = 1'b0;

  function automatic in_item_t gen_item();
    in_item_t it;
    int r;
    if ($urandom_range(0, 9) == 0) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 1)) it.rate_reference = '0;
      g_t = it.time_tick;
      g_ref = it.rate_reference;
      g_meas = it.rate_measured;
      return it;
    end
    if (g_seg == 0) begin
      g_seg = $urandom_range(3, 15);
      g_turn = $urandom_range(0, 1);
    end
    g_seg--;
    g_t += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 20);
    it.time_tick = g_t;
    it.speed_reference = ($urandom_range(0, 5) == 0) ? '0 : $urandom | 32'd1;
    if (!g_turn) begin
      g_ref = '0;
    end else begin
      r = $urandom_range(0, 9);
      if (r == 0 || $signed(g_ref) == 0)
        g_ref = 32'($urandom_range(0, 3 * ONE_Q) - ONE_Q * 3 / 2);
      else if (r == 1) g_ref = -$signed(g_ref);
      else if (r == 2) g_ref = $signed(g_ref) * 2;
      else if (r == 3) g_ref = $signed(g_ref) / 2;
      else if (r == 4) g_ref = $urandom_range(0, 200000) - 100000;
      else if (r < 7) g_ref = $signed(g_ref) + $signed($urandom_range(0, 40000)) - 20000;
    end
    it.rate_reference = g_ref;
    if ($urandom_range(0, 3) != 0)
      g_meas = 32'($signed(g_ref) + $signed($urandom_range(0, ONE_Q / 2)) - ONE_Q / 4);
    it.rate_measured = g_meas;
    if ($urandom_range(0, 19) == 0) g_head = $urandom;
    else if ($urandom_range(0, 9) == 0) g_head = 32'(($urandom_range(0, 1) ? PI_Q : -PI_Q));
    else g_head = $signed(g_head) + $signed($urandom_range(0, 400000)) - 200000;
    it.heading_measured = g_head;
    return it;
  endfunction

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    // First item after reset passes the reference through.
    '{'{32'd100, 32'sd0, 32'h7FFF_FFFF, 32'sd0, 32'sd0}, 1'b1, '{32'h7FFF_FFFF, 1'b0}},
    // Zero speed and zero reference give a zero command.
    '{'{32'd101, 32'sd0, 32'sd0, 32'sd5, 32'sd0}, 1'b1, '{32'sd0, 1'b0}},
    // Entering straight mode latches the heading with a zero command.
    '{'{32'd102, 32'sd65536, 32'sd0, 32'sd6, 32'sd1000}, 1'b1, '{32'sd0, 1'b0}},
    '{'{32'd110, 32'sd65536, 32'sd0, 32'sd7, -32'sd3000000}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd115, 32'sd65536, 32'sd0, 32'sd7, 32'sd3000000}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd130, 32'h8000_0000, 32'sd0, 32'sd8, 32'h8000_0000}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'sd0, 32'sd9, 32'h7FFF_FFFF}, 1'b0, '{32'sd0, 1'b0}},
    // Rise from near zero, sign change, ratio change, lock delay.
    '{'{32'd5, 32'sd65536, 32'sd1048576, 32'sd0, 32'sd0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd7, 32'sd65536, 32'sd1100000, 32'sd100, 32'sd0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd9, 32'sd65536, -32'sd1048576, 32'sd200, 32'sd0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd20, 32'sd65536, -32'sd3000000, 32'sd300, 32'sd0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd22, 32'sd65536, -32'sd1000000, 32'sd400, 32'sd0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd40, 32'sd65536, -32'sd1000000, 32'sd400, 32'sd0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd60, 32'sd65536, -32'sd1100000, 32'sd500, 32'sd0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd90, 32'sd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd95, 32'sd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd99, 32'sd1, 32'sd1, 32'sd1, 32'sd0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'd200, 32'sd0, 32'sd50000, 32'sd2, 32'sd0}, 1'b0, '{32'sd0, 1'b0}}
  };

  task automatic run_random(int count, bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 2) long_hold_req = 1'b1;
      send_item(gen_item());
    end
    drain();
  endtask

  initial begin
    head_kp = '0; head_ki = '0; rate_kp = '0; lock_delay = '0;
    m_first = 1'b1; m_straight = 1'b0;
    m_held = 0; m_err_sum = 0; m_last_ref = 0; m_last_meas = 0; m_last_cmd = 0;
    m_last_t = '0; m_jump_t = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_regs(32'h0100_0000, 32'h0010_0000, 32'h0080_0000, 16'd15);
    foreach (dir_rows[i]) begin
      typed_valid = dir_rows[i].typed;
      typed_cmd = dir_rows[i].res;
      send_item(dir_rows[i].it);
    end
    typed_valid = 1'b0;
    drain();

    write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    run_random(200, 1'b0);
    write_regs(32'h0, 32'h0, 32'h0, 16'h0);
    run_random(200, 1'b0);
    write_regs(32'h0200_0000, 32'h0004_0000, 32'h0040_0000, 16'd0);
    run_random(320, 1'b1);
    write_regs($urandom, $urandom, $urandom, 16'($urandom_range(0, 30)));
    run_random(320, 1'b0);

    repeat (300) @(negedge clk_i);
    if (err_count == 0 && cmd_expect_q.size() == 0) begin
      $display("[gyro_yaw_rate_correction_loop_core] OK");
    end else begin
      if (cmd_expect_q.size() != 0)
        $display("%0t: %0d results never arrived", $time, cmd_expect_q.size());
      $display("[gyro_yaw_rate_correction_loop_core] ERROR");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("[gyro_yaw_rate_correction_loop_core] ERROR");
    $finish;
  end

endmodule
